// File: sv/tcw_pkg.sv
// Shared types and constants for the text console writer.
package tcw_pkg;

  // Default screen geometry.
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Byte and cell widths.
  localparam int BYTE_W  = 8;
  localparam int CELL_W  = 16;
  localparam int INDEX_W = 11;

  // Character codes that move to the next row.
  localparam logic [BYTE_W-1:0] CODE_LINE_FEED       = 8'd10;
  localparam logic [BYTE_W-1:0] CODE_CARRIAGE_RETURN = 8'd13;

  // Attribute after reset.
  localparam logic [BYTE_W-1:0] ATTR_RESET = 8'd15;

  // Request modes.
  typedef enum logic [1:0] {
    MODE_WRITE  = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  // Sequencer states.
  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_PUT   = 13'b0000000000010,
    S_INC   = 13'b0000000000100,
    S_NL    = 13'b0000000001000,
    S_NL2   = 13'b0000000010000,
    S_DEL   = 13'b0000000100000,
    S_DEL1  = 13'b0000001000000,
    S_DEL2  = 13'b0000010000000,
    S_BLANK = 13'b0000100000000,
    S_SC_RD = 13'b0001000000000,
    S_SC_WR = 13'b0010000000000,
    S_RD    = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

endpackage

// File: sv/tcw_alu.sv
// Shared add/subtract and compare unit used by the console sequencer.
module tcw_alu #(
  parameter int VAL_W = 12
) (
  input  logic [VAL_W-1:0] op_a,
  input  logic [VAL_W-1:0] op_b,
  input  logic             sub,
  input  logic [VAL_W-1:0] lim,
  output logic [VAL_W-1:0] sum,
  output logic             ge
);

  logic [VAL_W-1:0] b_eff;

  // Subtraction adds the two's complement of the second operand.
  assign b_eff = sub ? ~op_b : op_b;
  assign sum   = op_a + b_eff + {{(VAL_W-1){1'b0}}, sub};

  // Limit compare on the result.
  assign ge = (sum >= lim);

endmodule

// File: sv/tcw_ram.sv
// Screen cell store with one write port and one registered read port.
module tcw_ram #(
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = 11,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/text_console_writer.sv
// Text console engine: cursor sequencer over a character/attribute cell store.
//
//   Channel   Ports                                           Handshake
//   request   start, in_mode, in_char_code, in_cell_index     start & !busy
//   result    out_valid, out_cursor_position, out_scrolled,   out_valid, one cycle
//             out_cell_char, out_cell_attr
//   config    cfg_valid, cfg_ready, cfg_text_attribute        cfg_valid & cfg_ready
//
// A scroll copies each body row up one row, cell by cell, then blanks the bottom row:
// one shared adder steps the pointer and the store has one read and one write port.
// After reset the store is swept to zero with busy high.
// Results cannot be stalled; busy stays high until the result strobe has gone by.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int SCREEN_COLUMNS = DEF_COLUMNS,
  parameter int SCREEN_ROWS    = DEF_ROWS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic [BYTE_W-1:0]  in_char_code,
  input  logic [INDEX_W-1:0] in_cell_index,
  output logic               out_valid,
  output logic [INDEX_W-1:0] out_cursor_position,
  output logic               out_scrolled,
  output logic [BYTE_W-1:0]  out_cell_char,
  output logic [BYTE_W-1:0]  out_cell_attr,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [BYTE_W-1:0]  cfg_text_attribute
);

  localparam int CELLS  = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(SCREEN_COLUMNS + 1);
  localparam int VAL_W  = ((ADDR_W > INDEX_W) ? ADDR_W : INDEX_W) + 1;

  localparam logic [VAL_W-1:0]  V_COLS     = VAL_W'(SCREEN_COLUMNS);
  localparam logic [VAL_W-1:0]  V_CELLS    = VAL_W'(CELLS);
  localparam logic [VAL_W-1:0]  V_BODY     = VAL_W'(CELLS - SCREEN_COLUMNS);
  localparam logic [VAL_W-1:0]  V_ONE      = VAL_W'(1);
  localparam logic [VAL_W-1:0]  V_ZERO     = '0;
  localparam logic [ADDR_W-1:0] LAST_START = ADDR_W'(CELLS - SCREEN_COLUMNS);

  state_t              state_r, state_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ADDR_W-1:0]   pos_r, pos_nxt;
  logic [ADDR_W-1:0]   ptr_r, ptr_nxt;
  logic [BYTE_W-1:0]   attr_r, attr_nxt;
  mode_t               mode_r, mode_nxt;
  logic [BYTE_W-1:0]   code_r, code_nxt;
  logic [INDEX_W-1:0]  index_r, index_nxt;
  logic                scrolled_r, scrolled_nxt;
  logic                rd_ok_r, rd_ok_nxt;
  logic                init_r, init_nxt;

  logic [VAL_W-1:0]    alu_a, alu_b, alu_lim, alu_sum;
  logic                alu_sub, alu_ge;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
  logic [CELL_W-1:0]   mem_wdata, mem_rdata;

  logic [VAL_W-1:0]    col_ext, pos_ext, ptr_ext, index_ext;
  logic [ADDR_W+INDEX_W-1:0] index_wide;
  logic [ADDR_W+INDEX_W-1:0] pos_wide;

  // Operand extension to the unit width.
  assign col_ext    = {{(VAL_W-COL_W){1'b0}}, col_r};
  assign pos_ext    = {{(VAL_W-ADDR_W){1'b0}}, pos_r};
  assign ptr_ext    = {{(VAL_W-ADDR_W){1'b0}}, ptr_r};
  assign index_ext  = {{(VAL_W-INDEX_W){1'b0}}, index_r};
  assign index_wide = {{ADDR_W{1'b0}}, index_r};
  assign pos_wide   = {{INDEX_W{1'b0}}, pos_r};

  tcw_alu #(
    .VAL_W(VAL_W)
  ) u_alu (
    .op_a(alu_a),
    .op_b(alu_b),
    .sub (alu_sub),
    .lim (alu_lim),
    .sum (alu_sum),
    .ge  (alu_ge)
  );

  tcw_ram #(
    .DEPTH (CELLS),
    .ADDR_W(ADDR_W),
    .DATA_W(CELL_W)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Sequencer: picks the unit's operands and the store access for each step.
  always_comb begin
    state_nxt    = state_r;
    col_nxt      = col_r;
    pos_nxt      = pos_r;
    ptr_nxt      = ptr_r;
    attr_nxt     = attr_r;
    mode_nxt     = mode_r;
    code_nxt     = code_r;
    index_nxt    = index_r;
    scrolled_nxt = scrolled_r;
    rd_ok_nxt    = rd_ok_r;
    init_nxt     = init_r;
    alu_a        = V_ZERO;
    alu_b        = V_ZERO;
    alu_sub      = 1'b0;
    alu_lim      = V_CELLS;
    mem_we       = 1'b0;
    mem_waddr    = ptr_r;
    mem_wdata    = '0;
    mem_raddr    = index_wide[ADDR_W-1:0];

    if (cfg_valid) begin
      attr_nxt = cfg_text_attribute;
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          mode_nxt     = mode_t'(in_mode);
          code_nxt     = in_char_code;
          index_nxt    = in_cell_index;
          scrolled_nxt = 1'b0;
          rd_ok_nxt    = 1'b0;
          case (mode_t'(in_mode))
            MODE_WRITE: begin
              if (in_char_code == CODE_LINE_FEED ||
                  in_char_code == CODE_CARRIAGE_RETURN) begin
                state_nxt = S_NL;
              end else begin
                state_nxt = S_PUT;
              end
            end
            MODE_DELETE: state_nxt = S_DEL;
            MODE_CLEAR: begin
              ptr_nxt   = '0;
              col_nxt   = '0;
              pos_nxt   = '0;
              state_nxt = S_BLANK;
            end
            MODE_READ: state_nxt = S_RD;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      // Store the character and step the column; wrap goes to a new line.
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = {attr_r, code_r};
        alu_a     = col_ext;
        alu_b     = V_ONE;
        alu_lim   = V_COLS;
        if (alu_ge) begin
          state_nxt = S_NL;
        end else begin
          col_nxt   = alu_sum[COL_W-1:0];
          state_nxt = S_INC;
        end
      end
      S_INC: begin
        alu_a     = pos_ext;
        alu_b     = V_ONE;
        pos_nxt   = alu_sum[ADDR_W-1:0];
        state_nxt = S_DONE;
      end
      // Back to the start of the row.
      S_NL: begin
        alu_a     = pos_ext;
        alu_b     = col_ext;
        alu_sub   = 1'b1;
        pos_nxt   = alu_sum[ADDR_W-1:0];
        col_nxt   = '0;
        state_nxt = S_NL2;
      end
      // Down one row, or scroll when already on the bottom row.
      S_NL2: begin
        alu_a   = pos_ext;
        alu_b   = V_COLS;
        alu_lim = V_CELLS;
        if (alu_ge) begin
          scrolled_nxt = 1'b1;
          ptr_nxt      = '0;
          state_nxt    = S_SC_RD;
        end else begin
          pos_nxt   = alu_sum[ADDR_W-1:0];
          state_nxt = S_DONE;
        end
      end
      // Delete does nothing at column zero.
      S_DEL: begin
        alu_a   = col_ext;
        alu_lim = V_ONE;
        if (alu_ge) begin
          state_nxt = S_DEL1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DEL1: begin
        alu_a     = col_ext;
        alu_b     = V_ONE;
        alu_sub   = 1'b1;
        col_nxt   = alu_sum[COL_W-1:0];
        state_nxt = S_DEL2;
      end
      S_DEL2: begin
        alu_a     = pos_ext;
        alu_b     = V_ONE;
        alu_sub   = 1'b1;
        pos_nxt   = alu_sum[ADDR_W-1:0];
        mem_we    = 1'b1;
        mem_waddr = alu_sum[ADDR_W-1:0];
        mem_wdata = {attr_r, {BYTE_W{1'b0}}};
        state_nxt = S_DONE;
      end
      // Scroll: read the cell one row below the pointer.
      S_SC_RD: begin
        alu_a     = ptr_ext;
        alu_b     = V_COLS;
        mem_raddr = alu_sum[ADDR_W-1:0];
        state_nxt = S_SC_WR;
      end
      // Scroll: write it one row up; after the last body row, blank the bottom row.
      S_SC_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = mem_rdata;
        alu_a     = ptr_ext;
        alu_b     = V_ONE;
        alu_lim   = V_BODY;
        ptr_nxt   = alu_sum[ADDR_W-1:0];
        if (alu_ge) begin
          state_nxt = S_BLANK;
        end else begin
          state_nxt = S_SC_RD;
        end
      end
      // Zero cells from the pointer to the end of the store.
      S_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = '0;
        alu_a     = ptr_ext;
        alu_b     = V_ONE;
        alu_lim   = V_CELLS;
        if (alu_ge) begin
          init_nxt = 1'b0;
          if (init_r) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          ptr_nxt = alu_sum[ADDR_W-1:0];
        end
      end
      // Read: range check while the store read is in flight.
      S_RD: begin
        alu_a     = index_ext;
        alu_lim   = V_CELLS;
        rd_ok_nxt = ~alu_ge;
        state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_BLANK;
      col_r      <= '0;
      pos_r      <= '0;
      ptr_r      <= '0;
      attr_r     <= ATTR_RESET;
      scrolled_r <= 1'b0;
      rd_ok_r    <= 1'b0;
      init_r     <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      col_r      <= col_nxt;
      pos_r      <= pos_nxt;
      ptr_r      <= ptr_nxt;
      attr_r     <= attr_nxt;
      scrolled_r <= scrolled_nxt;
      rd_ok_r    <= rd_ok_nxt;
      init_r     <= init_nxt;
    end
  end

  // Request payload registers.
  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    code_r  <= code_nxt;
    index_r <= index_nxt;
  end

  // Ports.
  assign busy                = (state_r != S_IDLE);
  assign cfg_ready           = 1'b1;
  assign out_valid           = (state_r == S_DONE);
  assign out_cursor_position = pos_wide[INDEX_W-1:0];
  assign out_scrolled        = scrolled_r;
  assign out_cell_char       = (rd_ok_r && mode_r == MODE_READ) ?
                               mem_rdata[BYTE_W-1:0] : '0;
  assign out_cell_attr       = (rd_ok_r && mode_r == MODE_READ) ?
                               mem_rdata[CELL_W-1:BYTE_W] : '0;

  // The store is never written while the block is idle.
  assert property (@(posedge clk) disable iff (!rst_n) !busy |-> !mem_we)
    else $error("store written while idle");

  // A result is followed by the idle state.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !busy)
    else $error("block busy after result");

  // The cursor stays on the screen.
  assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r < CELLS) && (col_r < SCREEN_COLUMNS))
    else $error("cursor off screen");

  // A scroll leaves the cursor at the start of the bottom row.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_scrolled) |-> (pos_r == LAST_START && col_r == '0))
    else $error("cursor misplaced after scroll");

endmodule
